>>> design/hsl2rgb_pkg.sv
// Constants, types and field layout for the HSL to RGB converter.
package hsl2rgb_pkg;

    // Field widths
    localparam int HUE_W   = 16;
    localparam int LEVEL_W = 13;
    localparam int ALPHA_W = 8;
    localparam int CHAN_W  = 8;

    // Packed stream widths, padded to whole bytes
    localparam int IN_BITS  = HUE_W + 2 * LEVEL_W + ALPHA_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 3 * CHAN_W + ALPHA_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Field positions in the input tdata
    localparam int SAT_LSB   = HUE_W;
    localparam int LIGHT_LSB = SAT_LSB + LEVEL_W;
    localparam int ALPHA_LSB = LIGHT_LSB + LEVEL_W;

    // Fixed-point formats: 1/16 degree hue, Q1.12 levels
    localparam int HUE_FRAC_BITS   = 4;
    localparam int LEVEL_FRAC_BITS = 12;
    localparam int SECTOR          = 60 << HUE_FRAC_BITS;   // 960
    localparam int FULL_TURN       = 6 * SECTOR;            // 5760
    localparam int LEVEL_ONE       = 1 << LEVEL_FRAC_BITS;  // 4096

    // Wrapped hue stays below one full turn, residue below one sector
    localparam int HW_W  = 13;
    localparam int RES_W = 10;
    // Hue shifted positive before wrapping: h + 6 * FULL_TURN fits in 17 bits
    localparam int HOFF_W = 17;
    localparam int HUE_OFFSET = 6 * FULL_TURN;

    // Pipeline depth
    localparam int STAGES = 6;

    // Datapath widths
    localparam int CS_W  = 25;  // (1 - |2L - 1|) * S, up to 2^24
    localparam int Z_W   = 26;  // 2 * ONE * L - cs, up to 2^25
    localparam int P_W   = 27;  // 2 * cs + z, up to 2^26
    localparam int CSU_W = 35;  // cs * (SECTOR - |t - SECTOR|)
    localparam int W_W   = 37;  // SECTOR * z + 2 * cs * u
    localparam int CV_W  = 10;  // channel before saturation

    // Sector of the hue circle
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    // Saturate a channel value to 8 bits
    function automatic logic [CHAN_W-1:0] sat_chan(input logic [CV_W-1:0] v);
        logic [CHAN_W-1:0] res;
        if (v > CV_W'((1 << CHAN_W) - 1)) begin
            res = '1;
        end else begin
            res = v[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> design/hsl_to_rgb_converter.sv
// Six-stage pipelined HSL to RGB color converter with stream handshakes.
// A pixel moves through the stage registers in order; stage 6 drives the output.
// Throughput: one pixel per cycle unless stalled; each stage holds while its successor is full
// and stalled, and empty stages fill behind a stall.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only; data registers keep.
module hsl_to_rgb_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // lsb up: hue[15:0] signed, saturation[12:0], lightness[12:0], alpha_in[7:0], zero pad
    input  logic [hsl2rgb_pkg::IN_W-1:0]  i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // lsb up: red[7:0], green[7:0], blue[7:0], alpha_out[7:0]
    output logic [hsl2rgb_pkg::OUT_W-1:0] o_m_axis_tdata
);

    localparam int NS = hsl2rgb_pkg::STAGES;

    // Per-stage valid bits and load enables
    logic [NS:1] r_vld;
    logic [NS:1] w_adv;

    // Move each stage when it is empty or its successor moves
    always_comb begin
        w_adv[NS] = !r_vld[NS] || i_m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_s_axis_tready = w_adv[1];
    assign o_m_axis_tvalid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- Stage 1: wrap hue, clamp levels ----------------
    logic signed [hsl2rgb_pkg::HUE_W-1:0]   w_hue;
    logic        [hsl2rgb_pkg::LEVEL_W-1:0] w_sat;
    logic        [hsl2rgb_pkg::LEVEL_W-1:0] w_light;
    logic        [hsl2rgb_pkg::HOFF_W-1:0]  n_hw;
    logic        [hsl2rgb_pkg::LEVEL_W-1:0] n_s1_sat;
    logic        [hsl2rgb_pkg::LEVEL_W-1:0] n_s1_light;
    logic        [hsl2rgb_pkg::HW_W-1:0]    r_s1_hw;
    logic        [hsl2rgb_pkg::LEVEL_W-1:0] r_s1_sat;
    logic        [hsl2rgb_pkg::LEVEL_W-1:0] r_s1_light;
    logic        [hsl2rgb_pkg::ALPHA_W-1:0] r_s1_alpha;

    assign w_hue   = i_s_axis_tdata[hsl2rgb_pkg::HUE_W-1:0];
    assign w_sat   = i_s_axis_tdata[hsl2rgb_pkg::SAT_LSB +: hsl2rgb_pkg::LEVEL_W];
    assign w_light = i_s_axis_tdata[hsl2rgb_pkg::LIGHT_LSB +: hsl2rgb_pkg::LEVEL_W];

    // Shift hue positive, then strip multiples of a full turn, one bit a step
    always_comb begin
        n_hw = hsl2rgb_pkg::HOFF_W'(
            (hsl2rgb_pkg::HOFF_W + 1)'(signed'(w_hue))
            + (hsl2rgb_pkg::HOFF_W + 1)'(hsl2rgb_pkg::HUE_OFFSET));
        for (int k = 3; k >= 0; k--) begin
            if (n_hw >= hsl2rgb_pkg::HOFF_W'(hsl2rgb_pkg::FULL_TURN << k)) begin
                n_hw = n_hw - hsl2rgb_pkg::HOFF_W'(hsl2rgb_pkg::FULL_TURN << k);
            end
        end
        n_s1_sat   = (w_sat > hsl2rgb_pkg::LEVEL_W'(hsl2rgb_pkg::LEVEL_ONE))
                   ? hsl2rgb_pkg::LEVEL_W'(hsl2rgb_pkg::LEVEL_ONE) : w_sat;
        n_s1_light = (w_light > hsl2rgb_pkg::LEVEL_W'(hsl2rgb_pkg::LEVEL_ONE))
                   ? hsl2rgb_pkg::LEVEL_W'(hsl2rgb_pkg::LEVEL_ONE) : w_light;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s1_hw    <= n_hw[hsl2rgb_pkg::HW_W-1:0];
            r_s1_sat   <= n_s1_sat;
            r_s1_light <= n_s1_light;
            r_s1_alpha <= i_s_axis_tdata[hsl2rgb_pkg::ALPHA_LSB +: hsl2rgb_pkg::ALPHA_W];
        end
    end

    // ---------------- Stage 2: sector, hue ramp, lightness span ----------------
    logic [hsl2rgb_pkg::HW_W-1:0]    n_res;
    logic [2:0]                      n_sec;
    logic [hsl2rgb_pkg::RES_W-1:0]   n_ramp;
    logic [hsl2rgb_pkg::LEVEL_W:0]   w_l2;
    logic [hsl2rgb_pkg::LEVEL_W-1:0] n_dl;
    logic [hsl2rgb_pkg::LEVEL_W-1:0] n_span;
    hsl2rgb_pkg::t_sector            r_s2_sec;
    logic [hsl2rgb_pkg::RES_W-1:0]   r_s2_ramp;
    logic [hsl2rgb_pkg::LEVEL_W-1:0] r_s2_span;
    logic [hsl2rgb_pkg::LEVEL_W-1:0] r_s2_sat;
    logic [hsl2rgb_pkg::LEVEL_W-1:0] r_s2_light;
    logic [hsl2rgb_pkg::ALPHA_W-1:0] r_s2_alpha;

    // Divide the wrapped hue by one sector, one quotient bit a step
    always_comb begin
        n_res = r_s1_hw;
        n_sec = '0;
        for (int k = 2; k >= 0; k--) begin
            if (n_res >= hsl2rgb_pkg::HW_W'(hsl2rgb_pkg::SECTOR << k)) begin
                n_res    = n_res - hsl2rgb_pkg::HW_W'(hsl2rgb_pkg::SECTOR << k);
                n_sec[k] = 1'b1;
            end
        end
        // Ramp rises in even sectors and falls in odd ones
        n_ramp = n_sec[0]
               ? hsl2rgb_pkg::RES_W'(hsl2rgb_pkg::HW_W'(hsl2rgb_pkg::SECTOR) - n_res)
               : n_res[hsl2rgb_pkg::RES_W-1:0];
        // |2L - ONE| and ONE minus it
        w_l2 = {r_s1_light, 1'b0};
        if (w_l2 >= (hsl2rgb_pkg::LEVEL_W + 1)'(hsl2rgb_pkg::LEVEL_ONE)) begin
            n_dl = hsl2rgb_pkg::LEVEL_W'(w_l2
                   - (hsl2rgb_pkg::LEVEL_W + 1)'(hsl2rgb_pkg::LEVEL_ONE));
        end else begin
            n_dl = hsl2rgb_pkg::LEVEL_W'((hsl2rgb_pkg::LEVEL_W + 1)'(hsl2rgb_pkg::LEVEL_ONE)
                   - w_l2);
        end
        n_span = hsl2rgb_pkg::LEVEL_W'(hsl2rgb_pkg::LEVEL_ONE) - n_dl;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s2_sec   <= hsl2rgb_pkg::t_sector'(n_sec);
            r_s2_ramp  <= n_ramp;
            r_s2_span  <= n_span;
            r_s2_sat   <= r_s1_sat;
            r_s2_light <= r_s1_light;
            r_s2_alpha <= r_s1_alpha;
        end
    end

    // ---------------- Stage 3: chroma product ----------------
    logic [hsl2rgb_pkg::CS_W-1:0]      n_cs;
    hsl2rgb_pkg::t_sector              r_s3_sec;
    logic [hsl2rgb_pkg::RES_W-1:0]     r_s3_ramp;
    logic [hsl2rgb_pkg::CS_W-1:0]      r_s3_cs;
    logic [hsl2rgb_pkg::LEVEL_W-1:0]   r_s3_light;
    logic [hsl2rgb_pkg::ALPHA_W-1:0]   r_s3_alpha;

    assign n_cs = hsl2rgb_pkg::CS_W'(r_s2_span) * hsl2rgb_pkg::CS_W'(r_s2_sat);

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s3_sec   <= r_s2_sec;
            r_s3_ramp  <= r_s2_ramp;
            r_s3_cs    <= n_cs;
            r_s3_light <= r_s2_light;
            r_s3_alpha <= r_s2_alpha;
        end
    end

    // ---------------- Stage 4: offset term and ramp product ----------------
    logic [hsl2rgb_pkg::Z_W-1:0]     w_lsh;
    logic [hsl2rgb_pkg::Z_W-1:0]     n_z;
    logic [hsl2rgb_pkg::CSU_W-1:0]   n_csu;
    hsl2rgb_pkg::t_sector            r_s4_sec;
    logic [hsl2rgb_pkg::CS_W-1:0]    r_s4_cs;
    logic [hsl2rgb_pkg::Z_W-1:0]     r_s4_z;
    logic [hsl2rgb_pkg::CSU_W-1:0]   r_s4_csu;
    logic [hsl2rgb_pkg::ALPHA_W-1:0] r_s4_alpha;

    // z = 2 * ONE * L - cs, floored at zero
    assign w_lsh = {r_s3_light, (hsl2rgb_pkg::LEVEL_FRAC_BITS + 1)'(0)};
    assign n_z   = (w_lsh >= hsl2rgb_pkg::Z_W'(r_s3_cs))
                 ? w_lsh - hsl2rgb_pkg::Z_W'(r_s3_cs) : '0;
    assign n_csu = hsl2rgb_pkg::CSU_W'(r_s3_cs) * hsl2rgb_pkg::CSU_W'(r_s3_ramp);

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s4_sec   <= r_s3_sec;
            r_s4_cs    <= r_s3_cs;
            r_s4_z     <= n_z;
            r_s4_csu   <= n_csu;
            r_s4_alpha <= r_s3_alpha;
        end
    end

    // ---------------- Stage 5: numerators, low channel ----------------
    logic [hsl2rgb_pkg::P_W-1:0]     n_p;
    logic [hsl2rgb_pkg::W_W-1:0]     n_w;
    logic [hsl2rgb_pkg::Z_W+7:0]     w_z255;
    hsl2rgb_pkg::t_sector            r_s5_sec;
    logic [hsl2rgb_pkg::P_W-1:0]     r_s5_p;
    logic [hsl2rgb_pkg::W_W-1:0]     r_s5_w;
    logic [hsl2rgb_pkg::CV_W-1:0]    r_s5_c0;
    logic [hsl2rgb_pkg::ALPHA_W-1:0] r_s5_alpha;

    // Full component: 2 * cs + z over 2^25
    assign n_p = {1'b0, r_s4_cs, 1'b0} + hsl2rgb_pkg::P_W'(r_s4_z);
    // Ramp component: 960 * z + 2 * cs * u, scaled by 17 over 2^31 later
    assign n_w = ({r_s4_z, 11'd0} >> 1) - hsl2rgb_pkg::W_W'({r_s4_z, 6'd0})
               + hsl2rgb_pkg::W_W'({r_s4_csu, 1'b0});
    // Zero component: z * 255 over 2^25
    assign w_z255 = {r_s4_z, 8'd0} - (hsl2rgb_pkg::Z_W + 8)'(r_s4_z);

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s5_sec   <= r_s4_sec;
            r_s5_p     <= n_p;
            r_s5_w     <= n_w;
            r_s5_c0    <= hsl2rgb_pkg::CV_W'(w_z255 >> 25);
            r_s5_alpha <= r_s4_alpha;
        end
    end

    // ---------------- Stage 6: scale, saturate, sector mapping ----------------
    logic [hsl2rgb_pkg::P_W+7:0]   w_p255;
    logic [hsl2rgb_pkg::W_W+4:0]   w_w17;
    logic [hsl2rgb_pkg::CHAN_W-1:0] w_cc;
    logic [hsl2rgb_pkg::CHAN_W-1:0] w_cx;
    logic [hsl2rgb_pkg::CHAN_W-1:0] w_c0;
    logic [hsl2rgb_pkg::CHAN_W-1:0] n_red;
    logic [hsl2rgb_pkg::CHAN_W-1:0] n_green;
    logic [hsl2rgb_pkg::CHAN_W-1:0] n_blue;
    logic [hsl2rgb_pkg::CHAN_W-1:0] r_red;
    logic [hsl2rgb_pkg::CHAN_W-1:0] r_green;
    logic [hsl2rgb_pkg::CHAN_W-1:0] r_blue;
    logic [hsl2rgb_pkg::ALPHA_W-1:0] r_alpha;

    assign w_p255 = {r_s5_p, 8'd0} - (hsl2rgb_pkg::P_W + 8)'(r_s5_p);
    assign w_w17  = {r_s5_w, 4'd0} + (hsl2rgb_pkg::W_W + 5)'(r_s5_w);
    assign w_cc   = hsl2rgb_pkg::sat_chan(hsl2rgb_pkg::CV_W'(w_p255 >> 25));
    assign w_cx   = hsl2rgb_pkg::sat_chan(hsl2rgb_pkg::CV_W'(w_w17 >> 31));
    assign w_c0   = hsl2rgb_pkg::sat_chan(r_s5_c0);

    // Route chroma, ramp and floor to the channels by sector
    always_comb begin
        unique case (r_s5_sec)
            hsl2rgb_pkg::SEC_RY: begin
                n_red = w_cc; n_green = w_cx; n_blue = w_c0;
            end
            hsl2rgb_pkg::SEC_YG: begin
                n_red = w_cx; n_green = w_cc; n_blue = w_c0;
            end
            hsl2rgb_pkg::SEC_GC: begin
                n_red = w_c0; n_green = w_cc; n_blue = w_cx;
            end
            hsl2rgb_pkg::SEC_CB: begin
                n_red = w_c0; n_green = w_cx; n_blue = w_cc;
            end
            hsl2rgb_pkg::SEC_BM: begin
                n_red = w_cx; n_green = w_c0; n_blue = w_cc;
            end
            default: begin
                n_red = w_cc; n_green = w_c0; n_blue = w_cx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_alpha <= r_s5_alpha;
        end
    end

    assign o_m_axis_tdata = hsl2rgb_pkg::OUT_W'({r_alpha, r_blue, r_green, r_red});

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the pipelined HSL to RGB color converter.
module testbench;
    import hsl2rgb_pkg::*;

    // Input transfer layout, lsb up: hue, saturation, lightness, alpha, zero pad
    typedef struct packed {
        logic [IN_W-IN_BITS-1:0] pad;
        logic [ALPHA_W-1:0]      alpha;
        logic [LEVEL_W-1:0]      light;
        logic [LEVEL_W-1:0]      sat;
        logic [HUE_W-1:0]        hue;
    } t_hsl_pixel;

    // Output transfer layout, lsb up: red, green, blue, alpha
    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
    } t_rgba;

    // One directed pixel; known rows carry the color expected at a glance
    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] sat;
        logic [LEVEL_W-1:0] light;
        logic [ALPHA_W-1:0] alpha;
        logic               known;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } t_color_row;

    localparam int N_DIRECTED     = 22;
    localparam int N_RANDOM       = 1550;
    localparam int DRAIN_AT       = 700;

    // Directed pixels: black, white, gray, primaries and secondaries on sector
    // boundaries, clamped levels, wrapped and extreme hues
    localparam t_color_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{16'd0,         13'd0,    13'd0,    8'h00, 1'b1, 8'd0,   8'd0,   8'd0},
        '{16'd0,         13'd4096, 13'd4096, 8'hFF, 1'b1, 8'd255, 8'd255, 8'd255},
        '{16'd0,         13'd8191, 13'd8191, 8'hA5, 1'b1, 8'd255, 8'd255, 8'd255},
        '{16'd0,         13'd0,    13'd2048, 8'h5A, 1'b1, 8'd127, 8'd127, 8'd127},
        '{16'd0,         13'd4096, 13'd2048, 8'hFF, 1'b1, 8'd255, 8'd0,   8'd0},
        '{16'd960,       13'd4096, 13'd2048, 8'h01, 1'b1, 8'd255, 8'd255, 8'd0},
        '{16'd1920,      13'd4096, 13'd2048, 8'h02, 1'b1, 8'd0,   8'd255, 8'd0},
        '{16'd2880,      13'd4096, 13'd2048, 8'h04, 1'b1, 8'd0,   8'd255, 8'd255},
        '{16'd3840,      13'd4096, 13'd2048, 8'h08, 1'b1, 8'd0,   8'd0,   8'd255},
        '{16'd4800,      13'd4096, 13'd2048, 8'h10, 1'b1, 8'd255, 8'd0,   8'd255},
        '{-16'sd5760,    13'd4096, 13'd2048, 8'h20, 1'b1, 8'd255, 8'd0,   8'd0},
        '{-16'sd960,     13'd4096, 13'd2048, 8'h40, 1'b1, 8'd255, 8'd0,   8'd255},
        '{16'd5760,      13'd4096, 13'd2048, 8'h80, 1'b1, 8'd255, 8'd0,   8'd0},
        '{16'd1920,      13'd8191, 13'd2048, 8'h7F, 1'b1, 8'd0,   8'd255, 8'd0},
        '{16'd1000,      13'd4097, 13'd4097, 8'h33, 1'b1, 8'd255, 8'd255, 8'd255},
        '{16'd959,       13'd4096, 13'd2048, 8'h11, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'h7FFF,      13'd4096, 13'd2048, 8'h22, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'h8000,      13'd4096, 13'd2048, 8'h44, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd480,       13'd4096, 13'd1024, 8'h88, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'd4321,      13'd1234, 13'd3000, 8'd77, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'hFFFF,      13'd4095, 13'd4095, 8'hC3, 1'b0, 8'd0,   8'd0,   8'd0},
        '{16'h5555,      13'h0AAA, 13'h1555, 8'h3C, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_W-1:0]     i_s_axis_tdata  = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    o_m_axis_tdata;

    // Color expected for the pixel currently offered, staged with its tdata
    t_rgba staged_rgba = '0;
    t_rgba pending_rgba [$];
    t_rgba got_rgba;
    t_rgba want_rgba;
    int    mismatch_count = 0;
    int    sink_cycle     = 0;
    int    stall_left     = 0;

    hsl_to_rgb_converter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hold reset low from the start, then release it for good
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Scale a numerator over the common denominator to an 8-bit channel
    function automatic logic [CHAN_W-1:0] to_channel(input longint num, input longint den);
        longint v;
        v = (num * 255) / den;
        return (v > 255) ? 8'hFF : CHAN_W'(v);
    endfunction

    // Exact integer HSL to RGB: clamp, wrap, form chroma, second component
    // and offset over one denominator, then map by sector
    function automatic t_rgba predict_rgba(input t_hsl_pixel px);
        longint one, sec, h, s, l, hw, t, dl, dt, cs, den, cn, xn, mn;
        longint comp_r, comp_g, comp_b;
        t_sector sector;
        t_rgba res;
        one = LEVEL_ONE;
        sec = SECTOR;
        h = longint'($signed(px.hue));
        s = px.sat;
        l = px.light;
        if (s > one) s = one;
        if (l > one) l = one;
        hw = h % (6 * sec);
        if (hw < 0) hw += 6 * sec;
        sector = t_sector'(3'(hw / sec));
        t = hw % (2 * sec);
        dl = 2 * l - one;
        if (dl < 0) dl = -dl;
        cs = (one - dl) * s;
        dt = t - sec;
        if (dt < 0) dt = -dt;
        den = 2 * one * one * sec;
        cn = cs * 2 * sec;
        xn = cs * 2 * (sec - dt);
        mn = l * 2 * one * sec - cs * sec;
        if (mn < 0) mn = 0;
        case (sector)
            SEC_RY: begin comp_r = cn; comp_g = xn; comp_b = 0;  end
            SEC_YG: begin comp_r = xn; comp_g = cn; comp_b = 0;  end
            SEC_GC: begin comp_r = 0;  comp_g = cn; comp_b = xn; end
            SEC_CB: begin comp_r = 0;  comp_g = xn; comp_b = cn; end
            SEC_BM: begin comp_r = xn; comp_g = 0;  comp_b = cn; end
            default: begin comp_r = cn; comp_g = 0;  comp_b = xn; end
        endcase
        res.red   = to_channel(comp_r + mn, den);
        res.green = to_channel(comp_g + mn, den);
        res.blue  = to_channel(comp_b + mn, den);
        res.alpha = px.alpha;
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Level: mostly in range, some exact ends, some above 1.0
    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return LEVEL_W'(LEVEL_ONE);
        if (r < 7) return LEVEL_W'($urandom_range(0, LEVEL_ONE));
        return LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1));
    endfunction

    // Hue: full random, near sector boundaries across turns, or one turn
    function automatic logic [HUE_W-1:0] pick_hue();
        int r, h;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            h = $urandom_range(0, (1 << HUE_W) - 1);
        end else if (r < 8) begin
            h = SECTOR * $urandom_range(0, 5) + $urandom_range(0, 4) - 2
                + FULL_TURN * ($urandom_range(0, 8) - 4);
        end else begin
            h = $urandom_range(0, FULL_TURN - 1);
        end
        return HUE_W'(h);
    endfunction

    // Offer one pixel after an optional idle stretch and hold until transfer
    task automatic send_pixel(input t_hsl_pixel px, input logic known, input t_rgba want,
                              input bit steady);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tdata  <= px;
        i_s_axis_tvalid <= 1'b1;
        staged_rgba     <= known ? want : predict_rgba(px);
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stop offering and wait until every expected color has come out
    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_rgba.size() != 0);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Sink: stall at random, with calm stretches of steady ready
    always @(posedge i_clk) begin
        sink_cycle++;
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (((sink_cycle / 400) % 3) != 1) stall_left = pick_gap();
        end
    end

    // Check each output transfer against the oldest expectation, then
    // record the expectation of each input transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_rgba = o_m_axis_tdata;
                if (pending_rgba.size() == 0) begin
                    mismatch_count++;
                    $error("result with no pixel pending: %h", got_rgba);
                end else begin
                    want_rgba = pending_rgba.pop_front();
                    compare_field("red",       want_rgba.red,   got_rgba.red);
                    compare_field("green",     want_rgba.green, got_rgba.green);
                    compare_field("blue",      want_rgba.blue,  got_rgba.blue);
                    compare_field("alpha_out", want_rgba.alpha, got_rgba.alpha);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) pending_rgba = {pending_rgba, staged_rgba};
        end
    end

    // Stimulus: directed table, then random pixels with one full drain midway
    initial begin : stimulus
        t_hsl_pixel px;
        t_rgba      want;
        while (!i_rst_n) @(posedge i_clk);
        foreach (DIRECTED_ROWS[i]) begin
            px.pad   = '0;
            px.hue   = DIRECTED_ROWS[i].hue;
            px.sat   = DIRECTED_ROWS[i].sat;
            px.light = DIRECTED_ROWS[i].light;
            px.alpha = DIRECTED_ROWS[i].alpha;
            want.red   = DIRECTED_ROWS[i].red;
            want.green = DIRECTED_ROWS[i].green;
            want.blue  = DIRECTED_ROWS[i].blue;
            want.alpha = DIRECTED_ROWS[i].alpha;
            send_pixel(px, DIRECTED_ROWS[i].known, want, 1'b0);
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == DRAIN_AT) drain_pipeline();
            px.pad   = '0;
            px.hue   = pick_hue();
            px.sat   = pick_level();
            px.light = pick_level();
            px.alpha = ALPHA_W'($urandom_range(0, 255));
            send_pixel(px, 1'b0, '0, ((i / 150) % 4) == 2);
        end
        drain_pipeline();
        repeat (2 * STAGES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin
        #12_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
